// ===== src/motion_tween_generator_macros.svh =====
// Assertion helpers used by the motion tween generator module.
`ifndef MOTION_TWEEN_GENERATOR_MACROS_SVH
`define MOTION_TWEEN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types and constants for the motion tween generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int ATAN_LEN = 24;
  localparam int CNT_W    = 5;
  localparam int PROD_W   = 68;
  localparam int OPND_W   = 34;
  localparam int TRIG_SH  = 30;

  localparam logic signed [33:0] CORDIC_GAIN_START = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Register indexes
  localparam logic [2:0] REG_START_XY     = 3'd0;
  localparam logic [2:0] REG_END_XY       = 3'd1;
  localparam logic [2:0] REG_SPEED_ACCEL  = 3'd2;
  localparam logic [2:0] REG_HEADING_TURN = 3'd3;
  localparam logic [2:0] REG_DURATION     = 3'd4;
  localparam logic [2:0] REG_INV_DURATION = 3'd5;
  localparam logic [2:0] REG_MODE         = 3'd6;

  // Modes
  localparam logic [3:0] MODE_LINEAR  = 4'd0;
  localparam logic [3:0] MODE_SQUARE  = 4'd1;
  localparam logic [3:0] MODE_CUBE    = 4'd2;
  localparam logic [3:0] MODE_QUART_L = 4'd3;
  localparam logic [3:0] MODE_QUART_H = 4'd6;
  localparam logic [3:0] MODE_SMOOTH  = 4'd7;
  localparam logic [3:0] MODE_SPEED   = 4'd8;
  localparam logic [3:0] MODE_ACCEL   = 4'd9;
  localparam logic [3:0] MODE_TURN    = 4'd10;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } cordic_rsp_t;

endpackage

// ===== src/mtg_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module mtg_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mtg_pkg::cordic_req_t req,
  output mtg_pkg::cordic_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic                            flip;
  logic [mtg_pkg::CNT_W-1:0]       cnt;
  logic signed [33:0]              x, y, z;
  logic signed [33:0]              x_sh, y_sh, atan_v;
  logic [31:0]                     ang_fold;

  assign ang_fold = {req.angle[31] ^ (req.angle[31] ^ req.angle[30]), req.angle[30:0]};
  assign x_sh     = x >>> cnt;
  assign y_sh     = y >>> cnt;
  assign atan_v   = signed'({2'b00, mtg_pkg::ATAN_TAB[cnt]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mtg_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Fold into +-90 degrees: flip when the angle sits in the back half-turn
  always_ff @(posedge clk) begin
    if (req.start) begin
      flip <= req.angle[31] ^ req.angle[30];
      x    <= mtg_pkg::CORDIC_GAIN_START;
      y    <= '0;
      z    <= 34'(signed'(ang_fold));
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_v;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_v;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.cos_v = flip ? -x : x;
  assign rsp.sin_v = flip ? -y : y;

endmodule

// ===== src/motion_tween_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_tween_generator
// Easing and heading-driven tween of one point, one shared multiplier.
// ----------------------------------------------------------------------------
// An arm beat loads the start point; it and a tick while idle give no result.
// A tick beat runs a sequence on one shared signed 34x34 multiplier, one
// product per cycle outside the CORDIC wait. The input stalls from acceptance
// until the result lands in the output register: easing modes 0..7 run S_T,
// S_T2, S_T3, S_T4, S_LX, S_LY, S_OUT; mode 8 runs S_T, S_D, the iterative
// CORDIC, S_MX, S_MY, S_OUT; mode 9 adds S_H and S_HE after S_D; mode 10 runs
// S_TURN and S_DSTEP in place of S_D; modes 11..15 go from S_T straight to
// S_OUT. A result held by out_stall adds its wait to the next tick; a result
// may sit in the output register while the next beat is taken.
module motion_tween_generator #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [31:0]        delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               finished
);

  localparam int TW = FRAC_BITS + 1;
  localparam int KW = FRAC_BITS + 3;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_T      = 17'h00002,
    S_T2     = 17'h00004,
    S_T3     = 17'h00008,
    S_T4     = 17'h00010,
    S_LX     = 17'h00020,
    S_LY     = 17'h00040,
    S_D      = 17'h00080,
    S_H      = 17'h00100,
    S_HE     = 17'h00200,
    S_TURN   = 17'h00400,
    S_DSTEP  = 17'h00800,
    S_CSTART = 17'h01000,
    S_CORD   = 17'h02000,
    S_MX     = 17'h04000,
    S_MY     = 17'h08000,
    S_OUT    = 17'h10000
  } state_t;

  state_t state;

  logic [63:0] start_xy, end_xy, speed_accel, heading_turn;
  logic [31:0] duration, inv_duration;
  logic [3:0]  mode;

  logic [31:0] elapsed, cur_x, cur_y, step;
  logic        active, fin;
  logic [TW-1:0] t, t2, t3, t4;
  logic [31:0] dlen, ang, px, py;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod, sh_f, sh_f1, sh_trig;
  logic [67:0]        one;
  logic [KW-1:0]      k;
  logic [32:0]        sum;
  logic               accept, tick_go;

  mtg_pkg::cordic_req_t creq;
  mtg_pkg::cordic_rsp_t crsp;

  mtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tick_go   = accept && (op == mtg_pkg::OP_TICK) && active;
  assign sum       = {1'b0, elapsed} + {1'b0, delta};

  assign creq.start = (state == S_CSTART);
  assign creq.angle = ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_xy     <= '0;
      end_xy       <= '0;
      speed_accel  <= '0;
      heading_turn <= '0;
      duration     <= 32'h0001_0000;
      inv_duration <= 32'h0001_0000;
      mode         <= mtg_pkg::MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtg_pkg::REG_START_XY:     start_xy     <= cfg_data;
        mtg_pkg::REG_END_XY:       end_xy       <= cfg_data;
        mtg_pkg::REG_SPEED_ACCEL:  speed_accel  <= cfg_data;
        mtg_pkg::REG_HEADING_TURN: heading_turn <= cfg_data;
        mtg_pkg::REG_DURATION:     duration     <= cfg_data[31:0];
        mtg_pkg::REG_INV_DURATION: inv_duration <= cfg_data[31:0];
        mtg_pkg::REG_MODE:         mode         <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Easing factor
  always_comb begin
    if (mode == mtg_pkg::MODE_SQUARE) begin
      k = KW'(t2);
    end else if (mode == mtg_pkg::MODE_CUBE) begin
      k = KW'(t3);
    end else if (mode inside {[mtg_pkg::MODE_QUART_L:mtg_pkg::MODE_QUART_H]}) begin
      k = KW'(t4);
    end else if (mode == mtg_pkg::MODE_SMOOTH) begin
      k = (KW'(t2) << 1) + KW'(t2) - (KW'(t3) << 1);
    end else begin
      k = KW'(t);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_T: begin
        mul_a = signed'({2'b00, elapsed});
        mul_b = signed'({2'b00, inv_duration});
      end
      S_T2: begin
        mul_a = signed'(34'(t));
        mul_b = signed'(34'(t));
      end
      S_T3: begin
        mul_a = signed'(34'(t2));
        mul_b = signed'(34'(t));
      end
      S_T4: begin
        mul_a = signed'(34'(t3));
        mul_b = signed'(34'(t));
      end
      S_LX: begin
        mul_a = signed'({{2{end_xy[63]}}, end_xy[63:32]}) - signed'({{2{cur_x[31]}}, cur_x});
        mul_b = signed'(34'(k));
      end
      S_LY: begin
        mul_a = signed'({{2{end_xy[31]}}, end_xy[31:0]}) - signed'({{2{cur_y[31]}}, cur_y});
        mul_b = signed'(34'(k));
      end
      S_D: begin
        mul_a = signed'({{2{speed_accel[63]}}, speed_accel[63:32]});
        mul_b = signed'({2'b00, elapsed});
      end
      S_H: begin
        mul_a = signed'({{2{speed_accel[31]}}, speed_accel[31:0]});
        mul_b = signed'({2'b00, elapsed});
      end
      S_HE: begin
        mul_a = signed'({{2{ang[31]}}, ang});
        mul_b = signed'({2'b00, elapsed});
      end
      S_TURN: begin
        mul_a = signed'({{2{heading_turn[31]}}, heading_turn[31:0]});
        mul_b = signed'(34'(t));
      end
      S_DSTEP: begin
        mul_a = signed'({{2{speed_accel[63]}}, speed_accel[63:32]});
        mul_b = signed'({2'b00, step});
      end
      S_MX: begin
        mul_a = signed'({{2{dlen[31]}}, dlen});
        mul_b = crsp.cos_v;
      end
      S_MY: begin
        mul_a = signed'({{2{dlen[31]}}, dlen});
        mul_b = crsp.sin_v;
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign sh_f    = prod >>> FRAC_BITS;
  assign sh_f1   = prod >>> (FRAC_BITS + 1);
  assign sh_trig = prod >>> mtg_pkg::TRIG_SH;
  assign one     = 68'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= 1'b0;
      elapsed   <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && op == mtg_pkg::OP_ARM) begin
            cur_x   <= start_xy[63:32];
            cur_y   <= start_xy[31:0];
            elapsed <= '0;
            active  <= 1'b1;
          end else if (tick_go) begin
            if (sum >= {1'b0, duration}) begin
              step    <= (elapsed < duration) ? duration - elapsed : '0;
              elapsed <= duration;
              fin     <= 1'b1;
            end else begin
              step    <= delta;
              elapsed <= sum[31:0];
              fin     <= 1'b0;
            end
            state <= S_T;
          end
        end
        S_T: begin
          t  <= (68'(sh_f) > one) ? TW'(one) : TW'(sh_f);
          px <= cur_x;
          py <= cur_y;
          if (mode <= mtg_pkg::MODE_SMOOTH) begin
            state <= S_T2;
          end else if (mode == mtg_pkg::MODE_SPEED || mode == mtg_pkg::MODE_ACCEL) begin
            state <= S_D;
          end else if (mode == mtg_pkg::MODE_TURN) begin
            state <= S_TURN;
          end else begin
            state <= S_OUT;
          end
        end
        S_T2: begin
          t2    <= TW'(sh_f);
          state <= S_T3;
        end
        S_T3: begin
          t3    <= TW'(sh_f);
          state <= S_T4;
        end
        S_T4: begin
          t4    <= TW'(sh_f);
          state <= S_LX;
        end
        S_LX: begin
          px    <= cur_x + sh_f[31:0];
          state <= S_LY;
        end
        S_LY: begin
          py    <= cur_y + sh_f[31:0];
          state <= S_OUT;
        end
        S_D: begin
          dlen  <= sh_f[31:0];
          ang   <= heading_turn[63:32];
          state <= (mode == mtg_pkg::MODE_ACCEL) ? S_H : S_CSTART;
        end
        S_H: begin
          // ang briefly holds the acceleration term h
          ang   <= sh_f[31:0];
          state <= S_HE;
        end
        S_HE: begin
          dlen  <= dlen + sh_f1[31:0];
          ang   <= heading_turn[63:32];
          state <= S_CSTART;
        end
        S_TURN: begin
          ang   <= heading_turn[63:32] + sh_f[31:0];
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          dlen  <= sh_f[31:0];
          state <= S_CSTART;
        end
        S_CSTART: begin
          state <= S_CORD;
        end
        S_CORD: begin
          if (crsp.done) begin
            state <= S_MX;
          end
        end
        S_MX: begin
          px <= cur_x + sh_trig[31:0];
          if (mode == mtg_pkg::MODE_TURN) begin
            cur_x <= cur_x + sh_trig[31:0];
          end
          state <= S_MY;
        end
        S_MY: begin
          py <= cur_y + sh_trig[31:0];
          if (mode == mtg_pkg::MODE_TURN) begin
            cur_y <= cur_y + sh_trig[31:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            pos_x     <= signed'(px);
            pos_y     <= signed'(py);
            finished  <= fin;
            if (fin) begin
              active <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "motion_tween_generator_macros.svh"

  `MTG_ASSERT_NEXT(a_idle_tick_drops, accept && op == mtg_pkg::OP_TICK && !active, !in_stall, "idle tick started work")
  `MTG_ASSERT_NEXT(a_arm_sets_active, accept && op == mtg_pkg::OP_ARM, active && !in_stall, "arm did not take")
  `MTG_ASSERT_NOW(a_cordic_done_in_wait, crsp.done, state == S_CORD, "CORDIC finished outside its wait")
  `MTG_ASSERT_NEXT(a_out_load_goes_idle, state == S_OUT && (!out_valid || !out_stall), out_valid && state == S_IDLE, "result not loaded")

endmodule
